// ===== sv/trie_keyword_matcher_top_assert.svh =====
// Assertion macros for the keyword trie matcher.
// Included by the top level; no other dependencies.
`ifndef TRIE_KEYWORD_MATCHER_TOP_ASSERT_SVH
`define TRIE_KEYWORD_MATCHER_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, disabled while reset is low.
`define TKM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tkm: assertion failed");
// Next-cycle implication, disabled while reset is low.
`define TKM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tkm: assertion failed");
`else
`define TKM_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define TKM_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/tkm_pkg.sv =====
// Shared types and constants of the keyword trie matcher.
// Used by the top level, tkm_clear and the testbench; depends on nothing.
package tkm_pkg;

    // Table sizes.
    localparam int MAX_NODES   = 256;
    localparam int MAX_SYMBOLS = 128;
    localparam int TYPE_BITS   = 6;

    // Derived widths.
    localparam int BYTE_W  = 8;
    localparam int NODE_W  = $clog2(MAX_NODES);
    localparam int SYM_W   = $clog2(MAX_SYMBOLS);
    localparam int NCNT_W  = $clog2(MAX_NODES + 1);
    localparam int SLOT_W  = NODE_W + SYM_W;
    localparam int CLR_W   = (SLOT_W > BYTE_W) ? SLOT_W : BYTE_W;
    localparam int KIND_W  = TYPE_BITS + 1;

    // Special node indexes and the empty token type.
    localparam logic [NODE_W-1:0]        DEAD_NODE = NODE_W'(0);
    localparam logic [NODE_W-1:0]        ROOT_NODE = NODE_W'(1);
    localparam logic signed [KIND_W-1:0] NO_TYPE   = {KIND_W{1'b1}};

    // Request function codes.
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_MATCH = 1'b1;

    // Result status codes, also used to record the first failure of a walk.
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_NO_MATCH   = 2'd1,
        ST_NODES_FULL = 2'd2,
        ST_SYMS_FULL  = 2'd3
    } t_status;

    // Position of the reset clearing sweep.
    typedef struct packed {
        logic             done;
        logic [CLR_W-1:0] addr;
    } t_clr;

endpackage

// ===== sv/trie_keyword_matcher_top.sv =====
// Keyword trie matcher: one byte per request, load or match mode.
// The result strobe is registered after the symbol and child steps of a last-byte request,
// and after the kind step as well for a successful match walk. A new request is taken only
// in idle, once the symbol map, child table and, for a last match byte, node kind reads are done.
// Reset: synchronous; a sweep over all 32768 addresses runs with busy high. No result stall.
// Depends on tkm_pkg, tkm_ram, tkm_clear and trie_keyword_matcher_top_assert.svh.
`include "trie_keyword_matcher_top_assert.svh"
module trie_keyword_matcher_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  logic                                 i_func,
    input  logic [tkm_pkg::BYTE_W-1:0]           i_byte_value,
    input  logic                                 i_last_byte,
    input  logic [tkm_pkg::TYPE_BITS-1:0]        i_token_type,
    output logic                                 o_result_valid,
    output logic [1:0]                           o_status,
    output logic signed [tkm_pkg::KIND_W-1:0]    o_matched_type
);

    // Sequencer states.
    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SYM   = 5'b00100,
        S_CHILD = 5'b01000,
        S_KIND  = 5'b10000
    } t_state;

    t_state                                r_state, n_state;
    logic [tkm_pkg::NODE_W-1:0]            r_cur, n_cur;
    tkm_pkg::t_status                      r_failed, n_failed;
    logic [tkm_pkg::SYM_W-1:0]             r_sym_count, n_sym_count;
    logic [tkm_pkg::NCNT_W-1:0]            r_node_count, n_node_count;
    logic [tkm_pkg::SYM_W-1:0]             r_sym, n_sym;
    logic                                  r_walk, n_walk;
    logic                                  r_func, n_func;
    logic [tkm_pkg::BYTE_W-1:0]            r_byte, n_byte;
    logic                                  r_last, n_last;
    logic [tkm_pkg::TYPE_BITS-1:0]         r_type, n_type;
    logic                                  r_out_valid, n_out_valid;
    tkm_pkg::t_status                      r_out_status, n_out_status;
    logic signed [tkm_pkg::KIND_W-1:0]     r_out_type, n_out_type;

    // Memory ports.
    logic                                  sym_we;
    logic [tkm_pkg::BYTE_W-1:0]            sym_waddr, sym_raddr;
    logic [tkm_pkg::SYM_W-1:0]             sym_wdata, sym_rd;
    logic                                  child_we;
    logic [tkm_pkg::SLOT_W-1:0]            child_waddr, child_raddr;
    logic [tkm_pkg::NODE_W-1:0]            child_wdata, child_rd;
    logic                                  kind_we;
    logic [tkm_pkg::NODE_W-1:0]            kind_waddr, kind_raddr;
    logic [tkm_pkg::KIND_W-1:0]            kind_wdata, kind_rd;

    // Walk step results.
    logic [tkm_pkg::SYM_W-1:0]             sym_v;
    logic                                  walk_v;
    logic [tkm_pkg::NODE_W-1:0]            step_cur;
    tkm_pkg::t_status                      step_fail;
    logic                                  accept;
    tkm_pkg::t_clr                         clr;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // Clearing sweep after reset.
    tkm_clear u_clear (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_run   (r_state == S_CLEAR),
        .o_clr   (clr)
    );

    // Byte to symbol map.
    tkm_ram #(.WIDTH(tkm_pkg::SYM_W), .DEPTH(2 ** tkm_pkg::BYTE_W)) u_sym_ram (
        .i_clk   (i_clk),
        .i_we    (sym_we),
        .i_waddr (sym_waddr),
        .i_wdata (sym_wdata),
        .i_raddr (sym_raddr),
        .o_rdata (sym_rd)
    );

    // Child node table indexed by node and symbol.
    tkm_ram #(.WIDTH(tkm_pkg::NODE_W), .DEPTH(2 ** tkm_pkg::SLOT_W)) u_child_ram (
        .i_clk   (i_clk),
        .i_we    (child_we),
        .i_waddr (child_waddr),
        .i_wdata (child_wdata),
        .i_raddr (child_raddr),
        .o_rdata (child_rd)
    );

    // Token type stored on each node.
    tkm_ram #(.WIDTH(tkm_pkg::KIND_W), .DEPTH(2 ** tkm_pkg::NODE_W)) u_kind_ram (
        .i_clk   (i_clk),
        .i_we    (kind_we),
        .i_waddr (kind_waddr),
        .i_wdata (kind_wdata),
        .i_raddr (kind_raddr),
        .o_rdata (kind_rd)
    );

    // Sequencer: symbol lookup, child lookup and update, then kind lookup or store.
    // Each memory is written only after its read for the same request, and a new
    // request is taken only in idle, so accesses to one entry never overlap.
    always_comb begin
        n_state      = r_state;
        n_cur        = r_cur;
        n_failed     = r_failed;
        n_sym_count  = r_sym_count;
        n_node_count = r_node_count;
        n_sym        = r_sym;
        n_walk       = r_walk;
        n_func       = r_func;
        n_byte       = r_byte;
        n_last       = r_last;
        n_type       = r_type;
        n_out_valid  = 1'b0;
        n_out_status = r_out_status;
        n_out_type   = r_out_type;

        sym_we      = 1'b0;
        sym_waddr   = r_byte;
        sym_wdata   = r_sym_count + tkm_pkg::SYM_W'(1);
        sym_raddr   = i_byte_value;
        child_we    = 1'b0;
        child_waddr = {r_cur, r_sym};
        child_wdata = r_node_count[tkm_pkg::NODE_W-1:0];
        child_raddr = {r_cur, r_sym};
        kind_we     = 1'b0;
        kind_waddr  = r_cur;
        kind_wdata  = {1'b0, r_type};
        kind_raddr  = r_cur;

        sym_v     = sym_rd;
        walk_v    = 1'b0;
        step_cur  = r_cur;
        step_fail = r_failed;

        unique case (r_state)
            S_CLEAR: begin
                sym_we      = 1'b1;
                sym_waddr   = clr.addr[tkm_pkg::BYTE_W-1:0];
                sym_wdata   = '0;
                child_we    = 1'b1;
                child_waddr = clr.addr[tkm_pkg::SLOT_W-1:0];
                child_wdata = tkm_pkg::DEAD_NODE;
                kind_we     = 1'b1;
                kind_waddr  = clr.addr[tkm_pkg::NODE_W-1:0];
                kind_wdata  = tkm_pkg::NO_TYPE;
                if (clr.done) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_func  = i_func;
                    n_byte  = i_byte_value;
                    n_last  = i_last_byte;
                    n_type  = i_token_type;
                    n_state = S_SYM;
                end
            end
            S_SYM: begin
                // Resolve the symbol; a new byte in load mode takes the next free one.
                if (r_failed == tkm_pkg::ST_OK) begin
                    if (sym_rd != '0) begin
                        walk_v = 1'b1;
                    end else if (r_func == tkm_pkg::FUNC_MATCH) begin
                        n_failed = tkm_pkg::ST_NO_MATCH;
                        n_cur    = tkm_pkg::DEAD_NODE;
                    end else if ((tkm_pkg::SYM_W + 1)'(r_sym_count) + (tkm_pkg::SYM_W + 1)'(1)
                                 >= (tkm_pkg::SYM_W + 1)'(tkm_pkg::MAX_SYMBOLS)) begin
                        n_failed = tkm_pkg::ST_SYMS_FULL;
                    end else begin
                        sym_v       = r_sym_count + tkm_pkg::SYM_W'(1);
                        n_sym_count = sym_v;
                        sym_we      = 1'b1;
                        walk_v      = 1'b1;
                    end
                end
                n_sym       = sym_v;
                n_walk      = walk_v;
                child_raddr = {r_cur, sym_v};
                n_state     = S_CHILD;
            end
            S_CHILD: begin
                // Follow the transition, creating the child node in load mode.
                if (r_walk) begin
                    if (r_func == tkm_pkg::FUNC_MATCH) begin
                        step_cur = child_rd;
                        if (child_rd == tkm_pkg::DEAD_NODE) begin
                            step_fail = tkm_pkg::ST_NO_MATCH;
                        end
                    end else if (child_rd != tkm_pkg::DEAD_NODE) begin
                        step_cur = child_rd;
                    end else if (r_node_count >= tkm_pkg::NCNT_W'(tkm_pkg::MAX_NODES)) begin
                        step_fail = tkm_pkg::ST_NODES_FULL;
                    end else begin
                        step_cur     = r_node_count[tkm_pkg::NODE_W-1:0];
                        n_node_count = r_node_count + tkm_pkg::NCNT_W'(1);
                        child_we     = 1'b1;
                    end
                end
                n_cur    = step_cur;
                n_failed = step_fail;
                n_state  = S_IDLE;
                // The end of the string reports and returns the walk to the root.
                if (r_last) begin
                    if (step_fail != tkm_pkg::ST_OK) begin
                        n_out_valid  = 1'b1;
                        n_out_status = step_fail;
                        n_out_type   = tkm_pkg::NO_TYPE;
                        n_cur        = tkm_pkg::ROOT_NODE;
                        n_failed     = tkm_pkg::ST_OK;
                    end else if (r_func == tkm_pkg::FUNC_LOAD) begin
                        kind_we      = 1'b1;
                        kind_waddr   = step_cur;
                        n_out_valid  = 1'b1;
                        n_out_status = tkm_pkg::ST_OK;
                        n_out_type   = tkm_pkg::NO_TYPE;
                        n_cur        = tkm_pkg::ROOT_NODE;
                        n_failed     = tkm_pkg::ST_OK;
                    end else begin
                        kind_raddr = step_cur;
                        n_state    = S_KIND;
                    end
                end
            end
            S_KIND: begin
                // Report the type stored on the node reached, or no match.
                n_out_valid = 1'b1;
                if (kind_rd[tkm_pkg::KIND_W-1]) begin
                    n_out_status = tkm_pkg::ST_NO_MATCH;
                    n_out_type   = tkm_pkg::NO_TYPE;
                end else begin
                    n_out_status = tkm_pkg::ST_OK;
                    n_out_type   = kind_rd;
                end
                n_cur    = tkm_pkg::ROOT_NODE;
                n_failed = tkm_pkg::ST_OK;
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_cur        <= tkm_pkg::ROOT_NODE;
            r_failed     <= tkm_pkg::ST_OK;
            r_sym_count  <= '0;
            r_node_count <= tkm_pkg::NCNT_W'(2);
            r_walk       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_cur        <= n_cur;
            r_failed     <= n_failed;
            r_sym_count  <= n_sym_count;
            r_node_count <= n_node_count;
            r_walk       <= n_walk;
            r_out_valid  <= n_out_valid;
        end
    end

    // Request and result payload registers.
    always_ff @(posedge i_clk) begin
        r_sym        <= n_sym;
        r_func       <= n_func;
        r_byte       <= n_byte;
        r_last       <= n_last;
        r_type       <= n_type;
        r_out_status <= n_out_status;
        r_out_type   <= n_out_type;
    end

    assign o_result_valid = r_out_valid;
    assign o_status       = r_out_status;
    assign o_matched_type = r_out_type;

    // A failed result never carries a token type.
    `TKM_ASSERT_IMP(a_fail_no_type, i_clk, i_rst_n, o_result_valid && (o_status != tkm_pkg::ST_OK), o_matched_type == tkm_pkg::NO_TYPE)
    // The result strobe lasts exactly one cycle.
    `TKM_ASSERT_NXT(a_strobe_single, i_clk, i_rst_n, o_result_valid, !o_result_valid)
    // An accepted request makes the block busy on the next cycle.
    `TKM_ASSERT_NXT(a_accept_busy, i_clk, i_rst_n, accept, busy)
    // Between requests the walk position is an allocated node.
    `TKM_ASSERT_IMP(a_cur_allocated, i_clk, i_rst_n, r_state == S_IDLE, tkm_pkg::NCNT_W'(r_cur) < r_node_count)

endmodule

// ===== sv/tkm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// Stand-alone; no package dependency.
module tkm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Read port with registered read data.
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/tkm_clear.sv =====
// Address sweep that clears the trie memories after reset.
// Depends on tkm_pkg for the sweep width and the t_clr struct.
module tkm_clear (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_run,
    output tkm_pkg::t_clr o_clr
);

    logic [tkm_pkg::CLR_W-1:0] r_addr;
    logic [tkm_pkg::CLR_W-1:0] n_addr;

    // Step one entry per cycle while the sweep runs.
    always_comb begin
        n_addr = r_addr;
        if (i_run) begin
            n_addr = r_addr + tkm_pkg::CLR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
        end else begin
            r_addr <= n_addr;
        end
    end

    // The sweep ends on the cycle that writes the highest address.
    assign o_clr.addr = r_addr;
    assign o_clr.done = i_run && (&r_addr);

endmodule

// ===== verif/trie_keyword_matcher_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for trie_keyword_matcher_top: random and directed byte requests.
// A queue-fed driver, a result monitor and an in-bench trie predictor; depends on tkm_pkg.
module trie_keyword_matcher_top_test;
    import tkm_pkg::*;

    localparam int STALL_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    // One byte request as driven on the ports.
    typedef struct packed {
        logic                 func;
        logic [BYTE_W-1:0]    byte_value;
        logic                 last;
        logic [TYPE_BITS-1:0] token;
    } t_byte_req;

    // Expected status and token type of one string.
    typedef struct packed {
        t_status                  status;
        logic signed [KIND_W-1:0] kind;
    } t_outcome;

    // A keyword of up to eight bytes, first byte in the low bits.
    typedef struct packed {
        logic [3:0]  len;
        logic [63:0] text;
    } t_keyword;

    logic                        i_clk = 1'b0;
    logic                        i_rst_n = 1'b0;
    logic                        start = 1'b0;
    logic                        busy;
    logic                        i_func = 1'b0;
    logic [BYTE_W-1:0]           i_byte_value = '0;
    logic                        i_last_byte = 1'b0;
    logic [TYPE_BITS-1:0]        i_token_type = '0;
    logic                        o_result_valid;
    logic [1:0]                  o_status;
    logic signed [KIND_W-1:0]    o_matched_type;

    // Stimulus and scoreboard storage.
    t_byte_req  byte_reqs[$];
    t_outcome   pending_outcomes[$];
    t_keyword   known_words[$];
    logic [7:0] alphabet[16];
    int         reqs_queued = 0;
    int         reqs_taken = 0;
    int         results_seen = 0;
    int         mismatches = 0;
    int         status_hits[4] = '{0, 0, 0, 0};
    int         stall_cycles = 0;

    // Driver state.
    t_byte_req  cur_req;
    logic       req_taken;
    int         gap_left = 0;
    int         burst_left = 0;
    t_outcome   want;

    // Trie predictor state.
    logic [7:0]               sym_of_byte[256];
    int unsigned              syms_given;
    logic [NODE_W-1:0]        child_of[MAX_NODES*MAX_SYMBOLS];
    logic signed [KIND_W-1:0] kind_of_node[MAX_NODES];
    int unsigned              nodes_given;
    logic [NODE_W-1:0]        walk_node;
    t_status                  walk_fail;

    trie_keyword_matcher_top u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_func         (i_func),
        .i_byte_value   (i_byte_value),
        .i_last_byte    (i_last_byte),
        .i_token_type   (i_token_type),
        .o_result_valid (o_result_valid),
        .o_status       (o_status),
        .o_matched_type (o_matched_type)
    );

    // Clock with a 10 ns period.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Empties the trie: only the dead node and the root exist.
    task automatic clear_trie();
        for (int i = 0; i < 256; i++) sym_of_byte[i] = '0;
        for (int i = 0; i < MAX_NODES * MAX_SYMBOLS; i++) child_of[i] = DEAD_NODE;
        for (int i = 0; i < MAX_NODES; i++) kind_of_node[i] = NO_TYPE;
        syms_given  = 0;
        nodes_given = 2;
        walk_node   = ROOT_NODE;
        walk_fail   = ST_OK;
    endtask

    // Advances the walk by one accepted byte and queues the outcome on a last byte.
    task automatic trie_step(input t_byte_req r);
        int unsigned              sym;
        int                       slot;
        logic [NODE_W-1:0]        nxt;
        t_outcome                 res;
        sym = sym_of_byte[r.byte_value];
        // Once a string has failed, its remaining bytes leave the trie alone.
        if (walk_fail == ST_OK) begin
            if (r.func == FUNC_MATCH) begin
                nxt = DEAD_NODE;
                if (sym != 0) nxt = child_of[int'(walk_node) * MAX_SYMBOLS + int'(sym)];
                walk_node = nxt;
                if (nxt == DEAD_NODE) walk_fail = ST_NO_MATCH;
            end else if (sym == 0 && syms_given + 1 >= MAX_SYMBOLS) begin
                walk_fail = ST_SYMS_FULL;
            end else begin
                if (sym == 0) begin
                    syms_given++;
                    sym = syms_given;
                    sym_of_byte[r.byte_value] = 8'(sym);
                end
                slot = int'(walk_node) * MAX_SYMBOLS + int'(sym);
                if (child_of[slot] == DEAD_NODE && nodes_given >= MAX_NODES) begin
                    walk_fail = ST_NODES_FULL;
                end else begin
                    if (child_of[slot] == DEAD_NODE) begin
                        child_of[slot] = NODE_W'(nodes_given);
                        kind_of_node[nodes_given] = NO_TYPE;
                        nodes_given++;
                    end
                    walk_node = child_of[slot];
                end
            end
        end
        // The last byte reports, stores a loaded type and sends the walk home.
        if (r.last) begin
            res.status = walk_fail;
            res.kind   = NO_TYPE;
            if (walk_fail == ST_OK) begin
                if (r.func == FUNC_MATCH) begin
                    res.kind = kind_of_node[walk_node];
                    if (res.kind == NO_TYPE) res.status = ST_NO_MATCH;
                end else begin
                    kind_of_node[walk_node] = {1'b0, r.token};
                end
            end
            pending_outcomes.push_back(res);
            walk_node = ROOT_NODE;
            walk_fail = ST_OK;
        end
    endtask

    // Gap before the next request: mostly none or short, a few long, some bursts with none.
    function automatic int pick_gap();
        int roll;
        if (burst_left > 0) begin
            burst_left--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
            burst_left = $urandom_range(20, 60);
            return 0;
        end
        if (roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Driver: presents queued requests and feeds each accepted one to the predictor.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start    <= 1'b0;
            gap_left = 0;
            clear_trie();
        end else begin
            req_taken = start && !busy;
            if (req_taken) begin
                trie_step(cur_req);
                reqs_taken++;
            end
            if (start && !req_taken) begin
                // Hold the request until the block takes it.
            end else if (gap_left > 0 || byte_reqs.size() == 0) begin
                if (gap_left > 0) gap_left--;
                start        <= 1'b0;
                i_func       <= 1'($urandom);
                i_byte_value <= 8'($urandom);
                i_last_byte  <= 1'($urandom);
                i_token_type <= TYPE_BITS'($urandom);
            end else begin
                cur_req = byte_reqs.pop_front();
                start        <= 1'b1;
                i_func       <= cur_req.func;
                i_byte_value <= cur_req.byte_value;
                i_last_byte  <= cur_req.last;
                i_token_type <= cur_req.token;
                gap_left = pick_gap();
            end
        end
    end

    // Monitor: checks every result strobe against the oldest expected outcome.
    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid === 1'b1) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("[%0t] result with none expected: status %0d type %0d",
                             $realtime, o_status, o_matched_type);
            end else begin
                want = pending_outcomes.pop_front();
                status_hits[o_status]++;
                if (o_status !== want.status || o_matched_type !== want.kind) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("[%0t] mismatch: status %0d (exp %0d) type %0d (exp %0d)",
                                 $realtime, o_status, want.status, o_matched_type, want.kind);
                end
            end
        end
    end

    // Watchdog: ends the run when neither requests nor results move for too long.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_result_valid === 1'b1) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles == STALL_LIMIT) begin
            $display("watchdog expired: %0d requests taken, %0d outcomes still due",
                     reqs_taken, pending_outcomes.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic push_req(input logic func, input logic [7:0] b, input logic last,
                            input logic [TYPE_BITS-1:0] token);
        t_byte_req r;
        r.func       = func;
        r.byte_value = b;
        r.last       = last;
        r.token      = token;
        byte_reqs.push_back(r);
        reqs_queued++;
    endtask

    // Sends a whole string under one function, the token type on its last byte.
    task automatic send_word(input logic func, input t_keyword w,
                             input logic [TYPE_BITS-1:0] token);
        for (int i = 0; i < w.len; i++)
            push_req(func, w.text[8*i +: 8], i == w.len - 1,
                     (i == w.len - 1) ? token : TYPE_BITS'($urandom));
    endtask

    function automatic t_keyword word_of(input string s);
        t_keyword w;
        w.len  = 4'(s.len());
        w.text = '0;
        for (int i = 0; i < s.len(); i++) w.text[8*i +: 8] = s[i];
        return w;
    endfunction

    // Random keyword, mostly from a small alphabet so that strings share prefixes, or any bytes if wide.
    function automatic t_keyword random_word(input bit wide);
        t_keyword w;
        w.len  = 4'($urandom_range(1, 5));
        w.text = '0;
        for (int i = 0; i < w.len; i++)
            w.text[8*i +: 8] = (wide || $urandom_range(0, 9) == 0) ?
                               8'($urandom_range(1, 255)) : alphabet[$urandom_range(0, 15)];
        return w;
    endfunction

    // One random string operation; load_pct sets how many are new keyword loads.
    task automatic random_string_op(input int load_pct);
        int       roll;
        int       n;
        t_keyword w;
        roll = $urandom_range(0, 99);
        if (known_words.size() > 0)
            w = known_words[$urandom_range(0, known_words.size() - 1)];
        if (roll < load_pct || known_words.size() == 0) begin
            w = random_word(1'b0);
            send_word(FUNC_LOAD, w, TYPE_BITS'($urandom));
            known_words.push_back(w);
        end else if (roll < load_pct + 30) begin
            send_word(FUNC_MATCH, w, TYPE_BITS'($urandom));
        end else if (roll < load_pct + 38) begin
            // A prefix of a keyword, which may carry no type of its own.
            if (w.len > 1) w.len = 4'($urandom_range(1, w.len - 1));
            send_word(FUNC_MATCH, w, TYPE_BITS'($urandom));
        end else if (roll < load_pct + 46) begin
            // A keyword with one extra byte.
            if (w.len < 8) begin
                w.text[8*w.len +: 8] = alphabet[$urandom_range(0, 15)];
                w.len++;
            end
            send_word(FUNC_MATCH, w, TYPE_BITS'($urandom));
        end else if (roll < load_pct + 54) begin
            send_word(FUNC_LOAD, w, TYPE_BITS'($urandom));
        end else if (roll < load_pct + 62) begin
            // Load and match bytes mixed within one string.
            for (int i = 0; i < w.len; i++)
                push_req(1'($urandom), w.text[8*i +: 8], i == w.len - 1,
                         TYPE_BITS'($urandom));
        end else if (roll < load_pct + 66) begin
            // An unterminated string: the next string goes on from where it stopped.
            w = random_word(1'b0);
            for (int i = 0; i < w.len; i++)
                push_req(1'($urandom), w.text[8*i +: 8], 1'b0, TYPE_BITS'($urandom));
        end else begin
            w = random_word(1'b1);
            n = w.len;
            for (int i = 0; i < n; i++)
                push_req(1'($urandom), w.text[8*i +: 8], i == n - 1, TYPE_BITS'($urandom));
        end
    endtask

    initial begin
        logic [7:0] sweep_order[255];
        logic [7:0] swap;
        int         j;
        t_keyword   w;

        for (int i = 0; i < 16; i++) alphabet[i] = 8'($urandom_range(1, 255));

        // Directed: store and find a keyword, a bare prefix, an unknown byte, a retyped key.
        send_word(FUNC_LOAD, word_of("ab"), 6'd5);
        send_word(FUNC_MATCH, word_of("ab"), 6'd0);
        send_word(FUNC_MATCH, word_of("a"), 6'd0);
        send_word(FUNC_MATCH, word_of("abz"), 6'd0);
        send_word(FUNC_LOAD, word_of("ab"), 6'd63);
        send_word(FUNC_MATCH, word_of("ab"), 6'd0);
        // Byte extremes with the smallest type.
        w.len  = 4'd2;
        w.text = {48'd0, 8'hFF, 8'h01};
        send_word(FUNC_LOAD, w, 6'd0);
        send_word(FUNC_MATCH, w, 6'd63);
        // Mixed modes: a load byte followed by a last match byte, and the reverse.
        push_req(FUNC_LOAD, "a", 1'b0, 6'd12);
        push_req(FUNC_MATCH, "b", 1'b1, 6'd0);
        push_req(FUNC_MATCH, "a", 1'b0, 6'd0);
        push_req(FUNC_LOAD, "q", 1'b1, 6'd33);
        send_word(FUNC_MATCH, word_of("aq"), 6'd0);
        // A failed walk ignores its later bytes, even ones that would match.
        send_word(FUNC_MATCH, word_of("zab"), 6'd0);
        known_words.push_back(word_of("ab"));
        known_words.push_back(word_of("aq"));

        // Random keyword loads and lookups; the node table fills up along the way.
        while (reqs_queued < 400) random_string_op(35);

        // Load every nonzero byte value as a one-byte keyword until the symbol space runs out.
        for (int i = 0; i < 255; i++) sweep_order[i] = 8'(i + 1);
        for (int i = 254; i > 0; i--) begin
            j = $urandom_range(0, i);
            swap = sweep_order[i];
            sweep_order[i] = sweep_order[j];
            sweep_order[j] = swap;
        end
        for (int i = 0; i < 255; i++) begin
            push_req(FUNC_LOAD, sweep_order[i], 1'b1, TYPE_BITS'($urandom));
            if ($urandom_range(0, 3) == 0) random_string_op(0);
        end

        // Lookups and retyping on the full trie.
        while (reqs_queued < 900) random_string_op(15);

        // Reset, then wait for every request and every outcome.
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (reqs_taken < reqs_queued || pending_outcomes.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Covered %0d byte requests and %0d results: %0d ok, %0d no match,",
                 reqs_taken, results_seen, status_hits[ST_OK], status_hits[ST_NO_MATCH]);
        $display("%0d node table full, %0d symbol table full; %0d mismatches.",
                 status_hits[ST_NODES_FULL], status_hits[ST_SYMS_FULL], mismatches);
        if (mismatches == 0 && pending_outcomes.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
